// ----- rtl/lbc3_pkg.sv -----
// Package for the 3x3 local binary code unit.
// Register indexes, field widths, reset values and types; no dependencies.
`timescale 1ns / 1ps

package lbc3_pkg;

	localparam int PIX_W      = 8;
	localparam int CODE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic             MODE_RST   = 1'b1;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	// smallest frame side the window can work on
	localparam int MIN_SIDE = 3;

	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [CODE_W-1:0] code_t;

endpackage

// ----- rtl/lbc3_if.sv -----
// Channel interfaces of the 3x3 local binary code unit: pixel in, code out,
// configuration writes. Depends on lbc3_pkg.
`timescale 1ns / 1ps

interface lbc3_pix_if;
	logic             valid;
	logic             ready;
	lbc3_pkg::pixel_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface lbc3_code_if;
	logic            valid;
	logic            ready;
	lbc3_pkg::code_t code;
	logic            frame_end;

	modport source (output valid, output code, output frame_end, input ready);
	modport sink   (input valid, input code, input frame_end, output ready);
endinterface

interface lbc3_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lbc3_pkg::CFG_IDX_W-1:0]    index;
	logic [lbc3_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/local_binary_code_3x3_unit.sv -----
// 3x3 local binary code unit: two line memories, 3x3 window, code output.
// Depends on lbc3_pkg and the channel interfaces in lbc3_if.sv.
// Pipeline: two register stages, line-memory read then code; an accepted pixel
//   sits in stage 1 with its read data, then its code (if interior) is registered.
// Throughput: one pixel per clock, set by the single read/write port pair of
//   each line memory; only a stalled output word holds the pipe.
// Reset: counters, window and valid flags clear at once; registers return to
//   mode 1, width 640, height 480. Line memories are not cleared.
`timescale 1ns / 1ps

module local_binary_code_3x3_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	lbc3_pix_if.sink    pix,
	lbc3_code_if.source res,
	lbc3_cfg_if.sink    cfg
);

	// Column index addresses the line memories directly.
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	// Compare widths: wide enough for the register field and for MAX+count.
	localparam int WCMP = (lbc3_pkg::WIDTH_W > COL_W + 1) ? lbc3_pkg::WIDTH_W : COL_W + 1;
	localparam int HCMP = (lbc3_pkg::HEIGHT_W > ROW_W + 1) ? lbc3_pkg::HEIGHT_W : ROW_W + 1;

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken.
	// ------------------------------------------------------------------
	logic                            mode_q;
	logic [lbc3_pkg::WIDTH_W-1:0]    width_q;
	logic [lbc3_pkg::HEIGHT_W-1:0]   height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lbc3_pkg::MODE_RST;
			width_q  <= lbc3_pkg::WIDTH_RST;
			height_q <= lbc3_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lbc3_pkg::REG_MODE:   mode_q   <= cfg.data[0];
				lbc3_pkg::REG_WIDTH:  width_q  <= cfg.data[lbc3_pkg::WIDTH_W-1:0];
				lbc3_pkg::REG_HEIGHT: height_q <= cfg.data[lbc3_pkg::HEIGHT_W-1:0];
				default: ;  // unused index: word dropped
			endcase
		end
	end

	// Effective frame size, clamped to [3, MAX].
	logic [WCMP-1:0] width_ext, width_eff;
	logic [HCMP-1:0] height_ext, height_eff;

	always_comb begin
		width_ext  = WCMP'(width_q);
		height_ext = HCMP'(height_q);
		if (width_ext < WCMP'(lbc3_pkg::MIN_SIDE))
			width_eff = WCMP'(lbc3_pkg::MIN_SIDE);
		else if (width_ext > WCMP'(MAX_WIDTH))
			width_eff = WCMP'(MAX_WIDTH);
		else
			width_eff = width_ext;
		if (height_ext < HCMP'(lbc3_pkg::MIN_SIDE))
			height_eff = HCMP'(lbc3_pkg::MIN_SIDE);
		else if (height_ext > HCMP'(MAX_HEIGHT))
			height_eff = HCMP'(MAX_HEIGHT);
		else
			height_eff = height_ext;
	end

	// ------------------------------------------------------------------
	// Handshake control
	// ------------------------------------------------------------------
	logic s1_valid_s1;   // stage 1 holds a pixel with its memory read data
	logic out_valid_q;
	logic s1_go;         // stage 1 may hand its word on
	logic s1_fire;
	logic in_fire;

	assign s1_go     = !out_valid_q || res.ready;
	assign s1_fire   = s1_valid_s1 && s1_go;
	assign pix.ready = !s1_valid_s1 || s1_go;
	assign in_fire   = pix.valid && pix.ready;

	// ------------------------------------------------------------------
	// Stage 0: position counters, issue line memory read at the column.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col, last_row, interior;

	assign last_col = (WCMP'(col_q) + WCMP'(1)) >= width_eff;
	assign last_row = (HCMP'(row_q) + HCMP'(1)) >= height_eff;
	assign interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 registers: pixel, column, emit flags.
	lbc3_pkg::pixel_t pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1, fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (pix.ready)
			s1_valid_s1 <= pix.valid;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_s1 <= pix.pixel;
			col_s1   <= col_q;
			emit_s1  <= interior;
			fend_s1  <= last_col && last_row;
		end
	end

	// ------------------------------------------------------------------
	// Line memories: read at stage 0 column, written back from stage 1.
	// Read and write columns never coincide (width >= 3), so no bypass.
	// Read data only loads on an accepted pixel, so it holds over a stall.
	// ------------------------------------------------------------------
	lbc3_pkg::pixel_t upper_mem [MAX_WIDTH];
	lbc3_pkg::pixel_t middle_mem [MAX_WIDTH];
	lbc3_pkg::pixel_t upper_rd_s1, middle_rd_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			upper_rd_s1  <= upper_mem[col_q];
			middle_rd_s1 <= middle_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			upper_mem[col_s1]  <= middle_rd_s1;
			middle_mem[col_s1] <= pixel_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: window of the two previous columns plus the fresh column
	// (upper read, middle read, incoming pixel). Center is win_q[4].
	//   win_q[0..2] = upper/middle/lower two columns back
	//   win_q[3..5] = upper/middle/lower one column back
	// ------------------------------------------------------------------
	lbc3_pkg::pixel_t win_q [6];
	lbc3_pkg::pixel_t ctr;
	lbc3_pkg::code_t  code_8n, code_4n;
	logic             ge_up, ge_ur, ge_rt, ge_dr, ge_dn, ge_dl, ge_lt, ge_ul;

	always_comb begin
		ctr   = win_q[4];
		ge_up = win_q[3] >= ctr;
		ge_ur = upper_rd_s1 >= ctr;
		ge_rt = middle_rd_s1 >= ctr;
		ge_dr = pixel_s1 >= ctr;
		ge_dn = win_q[5] >= ctr;
		ge_dl = win_q[2] >= ctr;
		ge_lt = win_q[1] >= ctr;
		ge_ul = win_q[0] >= ctr;
		// clockwise from up, weight 1 .. 128
		code_8n = {ge_ul, ge_lt, ge_dl, ge_dn, ge_dr, ge_rt, ge_ur, ge_up};
		// left 128, fixed 64, right 32, up 16, down 1
		code_4n = {ge_lt, 1'b1, ge_rt, ge_up, 3'b000, ge_dn};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (s1_fire) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= upper_rd_s1;
			win_q[4] <= middle_rd_s1;
			win_q[5] <= pixel_s1;
		end
	end

	// ------------------------------------------------------------------
	// Output register; a waiting word stalls stage 1 and, once stage 1 is full, stage 0.
	// ------------------------------------------------------------------
	lbc3_pkg::code_t code_q;
	logic            fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go)
			out_valid_q <= s1_valid_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			code_q <= mode_q ? code_8n : code_4n;
			fend_q <= fend_s1;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.code      = code_q;
	assign res.frame_end = fend_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Write-back never lands on the column being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && in_fire) |-> (col_s1 != col_q))
		else $error("line memory read and write hit the same column");

	// Last pixel of a frame wraps both counters.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_col && last_row) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");

	// A stalled stage 1 keeps its column and memory read data.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_go) |=>
		(s1_valid_s1 && $stable(col_s1) && $stable(middle_rd_s1)))
		else $error("stage 1 lost its word during a stall");

	// Column counter stays inside the line memory.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (WCMP'(col_q) < WCMP'(MAX_WIDTH)))
		else $error("column counter beyond line memory");

endmodule

// ----- test/tb_local_binary_code_3x3_unit.sv -----
// Self-checking testbench for the 3x3 local binary code unit: raster pixel stream in,
// one code word per interior pixel out, checked against a cycle-free predictor.
// Depends on lbc3_pkg, the channel interfaces in lbc3_if.sv and the unit itself.
`timescale 1ns / 1ps

module tb_local_binary_code_3x3_unit;
	import lbc3_pkg::*;

	localparam int unsigned MAX_W        = 1024;
	localparam int unsigned MAX_H        = 4096;
	localparam int          RANDOM_ITEMS = 1350;
	// unit has two register stages; the settle wait covers border pixels still in flight
	localparam int          SETTLE_CYCLES = 6;
	// ~18k pixel words under the heaviest stalls, plus
	// the pauses around register writes; taken several times over
	localparam int          CYCLE_LIMIT   = 400000;
	// index with no register behind it; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {TEX_NOISE, TEX_NEAR, TEX_FLAT, TEX_BINARY} texture_t;

	typedef struct packed {
		code_t code;
		logic  frame_end;
	} code_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n;

	lbc3_pix_if  pix_ch();
	lbc3_code_if res_ch();
	lbc3_cfg_if  cfg_ch();

	local_binary_code_3x3_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Stimulus stores and run bookkeeping
	// ------------------------------------------------------------------
	pixel_t     pix_queue[$];      // pixel words waiting for the driver
	reg_write_t cfg_queue[$];      // register writes waiting for the driver
	code_word_t pending_codes[$];  // predicted code words, oldest first

	int src_idle_pct = 9;
	int rcv_idle_pct = 59;

	// handshake flags, refreshed at every rising edge and used by the driver
	// at the following falling edge
	bit pix_fire;
	bit cfg_fire;
	bit res_fire;

	int cycle_count;
	int fails;
	int pixels_in;
	int codes_out;
	int reg_writes;

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the registers, both line stores,
	// the six window pixels of the two previous columns and the position
	// of the next incoming pixel
	// ------------------------------------------------------------------
	logic                mode_eight;
	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	pixel_t              line_two_up[MAX_W];
	pixel_t              line_one_up[MAX_W];
	pixel_t              win_px[6];   // [0..2] column-2 up/mid/low, [3..5] column-1
	int unsigned         col_pos;
	int unsigned         row_pos;

	// sizes out of range are pinned to the legal span
	function automatic int unsigned side_limit(input int unsigned v, input int unsigned hi);
		if (v < MIN_SIDE)
			return MIN_SIDE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_MODE:   mode_eight = value[0];
			REG_WIDTH:  width_reg  = value[WIDTH_W-1:0];
			REG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
			default: ;
		endcase
	endfunction

	// One accepted pixel: emit the code of the window center if it is
	// interior, then shift the line stores, the window and the position.
	function automatic void advance_window(input pixel_t px);
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned rd_col;
		pixel_t      two_up;
		pixel_t      one_up;
		pixel_t      ctr;
		logic        col_end;
		logic        row_end;
		code_word_t  word;

		w_eff   = side_limit(width_reg, MAX_W);
		h_eff   = side_limit(height_reg, MAX_H);
		rd_col  = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
		two_up  = line_two_up[rd_col];
		one_up  = line_one_up[rd_col];
		col_end = (col_pos >= w_eff - 1);
		row_end = (row_pos >= h_eff - 1);

		if (row_pos >= 2 && col_pos >= 2) begin
			ctr = win_px[4];
			// neighbor at least the center sets its bit; equal counts as set
			if (mode_eight)
				word.code = {win_px[0] >= ctr, win_px[1] >= ctr, win_px[2] >= ctr,
					win_px[5] >= ctr, px >= ctr, one_up >= ctr, two_up >= ctr,
					win_px[3] >= ctr};
			else
				// left 128, constant 64, right 32, up 16, down 1
				word.code = {win_px[1] >= ctr, 1'b1, one_up >= ctr, win_px[3] >= ctr,
					3'b000, win_px[5] >= ctr};
			word.frame_end = col_end && row_end;
			pending_codes.push_back(word);
		end

		line_two_up[rd_col] = one_up;
		line_one_up[rd_col] = px;
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = two_up;
		win_px[4] = one_up;
		win_px[5] = px;

		if (col_end) begin
			col_pos = 0;
			row_pos = row_end ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	// pixels still needed to close the current frame under the present sizes,
	// a whole frame when sitting on a frame boundary
	function automatic int unsigned pixels_to_frame_end();
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned n;
		w_eff = side_limit(width_reg, MAX_W);
		h_eff = side_limit(height_reg, MAX_H);
		n = (col_pos >= w_eff - 1) ? 1 : w_eff - col_pos;
		if (row_pos < h_eff - 1)
			n += (h_eff - 1 - row_pos) * w_eff;
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Driver: loads the next word at the falling edge once the previous one
	// has been taken, with random gaps on the sender side
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix_ch.valid || pix_fire) begin
				if (pix_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					pix_ch.valid <= 1'b1;
					pix_ch.pixel <= pix_queue.pop_front();
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
			if (!cfg_ch.valid || cfg_fire) begin
				if (cfg_queue.size() != 0) begin
					reg_write_t wr;
					wr = cfg_queue.pop_front();
					cfg_ch.valid <= 1'b1;
					cfg_ch.index <= wr.index;
					cfg_ch.data  <= wr.data;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
		// receiver back-pressure
		res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Monitor: samples all three channels at the rising edge, feeds the
	// predictor and checks every code word against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		code_word_t want;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d code words outstanding",
				cycle_count, pending_codes.size());
			$display("FAILURE");
			$finish;
		end else begin
			cycle_count++;
			if (arst_n) begin
				pix_fire = pix_ch.valid && pix_ch.ready;
				cfg_fire = cfg_ch.valid && cfg_ch.ready;
				res_fire = res_ch.valid && res_ch.ready;
				if (cfg_fire) begin
					apply_register(cfg_ch.index, cfg_ch.data);
					reg_writes++;
				end
				if (pix_fire) begin
					advance_window(pix_ch.pixel);
					pixels_in++;
				end
				if (res_fire) begin
					codes_out++;
					if (pending_codes.size() == 0) begin
						$error("unexpected code word: code %0h frame_end %0b",
							res_ch.code, res_ch.frame_end);
						fails++;
					end else begin
						want = pending_codes.pop_front();
						if (res_ch.code !== want.code) begin
							$error("code: expected %0h, actual %0h", want.code, res_ch.code);
							fails++;
						end
						if (res_ch.frame_end !== want.frame_end) begin
							$error("frame_end: expected %0b, actual %0b",
								want.frame_end, res_ch.frame_end);
							fails++;
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic pixel_t pick_pixel(input texture_t tex, input int base);
		int v;
		case (tex)
			TEX_NEAR: begin
				// tight spread around a base level, so ties with the center are common
				v = base + $urandom_range(0, 4) - 2;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return v;
			end
			TEX_FLAT:   return base;
			TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:    return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic feed_pixels(input int unsigned n, input texture_t tex, input int base);
		for (int unsigned i = 0; i < n; i++)
			pix_queue.push_back(pick_pixel(tex, base));
	endtask

	// wait until every word is out and every prediction has been met,
	// then give the pipe time to finish border pixels
	task automatic settle();
		do
			@(posedge clk);
		while (pix_queue.size() != 0 || pix_ch.valid || cfg_queue.size() != 0 ||
			cfg_ch.valid || pending_codes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// registers only change with the unit idle; returns once the write has landed
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		reg_write_t wr;
		settle();
		wr.index = idx;
		wr.data  = value;
		cfg_queue.push_back(wr);
		settle();
	endtask

	// width field mostly small, sometimes below the minimum; the bits above
	// the field are junk that must be ignored
	function automatic logic [CFG_DATA_W-1:0] random_width_data();
		logic [CFG_DATA_W-1:0] d;
		d = $urandom_range(0, 8191);
		d[WIDTH_W-1:0] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
			: $urandom_range(3, 16);
		return d;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_height_data();
		logic [CFG_DATA_W-1:0] d;
		d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
		return d;
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		texture_t    tex;
		int          base;
		int          random_items;
		int unsigned frame_px;
		int unsigned cut;
		int unsigned rest;

		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;

		mode_eight = MODE_RST;
		width_reg  = WIDTH_RST;
		height_reg = HEIGHT_RST;
		foreach (line_two_up[i]) begin
			line_two_up[i] = '0;
			line_one_up[i] = '0;
		end
		foreach (win_px[i])
			win_px[i] = '0;
		col_pos = 0;
		row_pos = 0;

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset sizes and eight-neighbor mode: two full rows of 640 and a bit
		// of the third. This also fills both line stores for every column up to
		// 640, so later size changes never read an unwritten entry.
		feed_pixels(2 * WIDTH_RST + 10, TEX_NOISE, 0);
		// shrink mid-frame: column and row are already past the new ends,
		// so the very next pixel closes the frame
		write_reg(REG_WIDTH, 13'd8);
		write_reg(REG_HEIGHT, 13'd3);
		feed_pixels(pixels_to_frame_end(), TEX_NOISE, 0);

		// Directed 3x3 frames at the smallest size.
		// four-neighbor via bit 0 of a junk-laden word; width and height below minimum
		write_reg(REG_MODE, 13'h1FFE);
		write_reg(REG_WIDTH, 13'h1802);
		write_reg(REG_HEIGHT, 13'd0);
		feed_pixels(9, TEX_FLAT, 8'h80);           // all ties: every neighbor bit set
		write_reg(REG_MODE, 13'h0001);
		for (int i = 0; i < 9; i++)                // dark center, white ring
			pix_queue.push_back((i == 4) ? 8'h00 : 8'hFF);
		write_reg(REG_SPARE, 13'h1FFF);            // no register here
		feed_pixels(9, TEX_NOISE, 0);

		// Random frames; receiver-heavy gaps first, then sender-heavy, then none.
		// A quarter of the frames get a size or mode change part way through.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (random_items * 3 / RANDOM_ITEMS)
				0: begin
					src_idle_pct = 9;
					rcv_idle_pct = 59;
				end
				1: begin
					src_idle_pct = 59;
					rcv_idle_pct = 9;
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			if ($urandom_range(0, 1))
				write_reg(REG_MODE, $urandom_range(0, 8191));
			if ($urandom_range(0, 9) < 7) begin
				write_reg(REG_WIDTH, random_width_data());
				write_reg(REG_HEIGHT, random_height_data());
			end
			tex  = texture_t'($urandom_range(0, 3));
			base = $urandom_range(0, 255);
			frame_px = side_limit(width_reg, MAX_W) * side_limit(height_reg, MAX_H);
			if ($urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, frame_px - 1);
				feed_pixels(cut, tex, base);
				case ($urandom_range(0, 2))
					0: write_reg(REG_WIDTH, random_width_data());
					1: write_reg(REG_HEIGHT, random_height_data());
					default: write_reg(REG_MODE, $urandom_range(0, 8191));
				endcase
				rest = pixels_to_frame_end();
				feed_pixels(rest, tex, base);
				random_items += cut + rest;
			end else begin
				feed_pixels(frame_px, tex, base);
				random_items += frame_px;
			end
		end

		// Size extremes at full rate.
		// all-ones width field pins to the widest line; height below minimum
		write_reg(REG_MODE, 13'd0);
		write_reg(REG_WIDTH, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'd1);
		feed_pixels(pixels_to_frame_end(), TEX_NOISE, 0);
		// tallest frame on the narrowest line
		write_reg(REG_MODE, 13'd1);
		write_reg(REG_WIDTH, 13'd3);
		write_reg(REG_HEIGHT, 13'd4096);
		feed_pixels(pixels_to_frame_end(), TEX_NOISE, 0);
		// height above the limit must not end the frame early; then cut it short
		write_reg(REG_HEIGHT, 13'h1FFF);
		feed_pixels(12, TEX_NEAR, 128);
		write_reg(REG_HEIGHT, 13'd3);
		feed_pixels(pixels_to_frame_end(), TEX_NEAR, 128);

		settle();
		$display("run covered %0d pixel words, %0d code words and %0d register writes",
			pixels_in, codes_out, reg_writes);
		$display("both neighbor modes, size clamps, mid-frame size changes, %0d mismatches",
			fails);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
